// ----- rtl/core/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timed event queue
// Entry layout, opcode and status codes, sequencer states, compare flags.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned ID_W            = 16;
	// at most this many fired events are reported by one advance
	localparam int unsigned MAX_FIRED       = 16;
	localparam int unsigned FIRED_W         = 5;
	localparam int unsigned REMOVED_W       = 5;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_LIST_ADD = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_ADVANCE  = 2'd3
	} teq_op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_REJ_EMPTY = 2'd1,
		STAT_REJ_PAST  = 2'd2,
		STAT_FULL      = 2'd3
	} teq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WALK,
		S_CMP_RD,
		S_CMP_WALK,
		S_FLUSH
	} teq_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] due_time;
		logic [ID_W-1:0]   event_id;
	} teq_entry_t;

	typedef struct packed {
		logic lt_ab;
		logic eq_ab;
		logic gt_ac;
	} teq_cmp_t;

endpackage

// ----- rtl/core/teq_cmp.sv -----
// ----------------------------------------------------------------------------
// teq_cmp: shared time comparator
// Compares one time against two references; used by the idle, insert and compare-walk steps.
// ----------------------------------------------------------------------------
module teq_cmp import teq_pkg::*; (
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	input  logic [TIME_W-1:0] c,
	output teq_cmp_t          flags
);

	assign flags.lt_ab = (a < b);
	assign flags.eq_ab = (a == b);
	assign flags.gt_ac = (a > c);

endmodule

// ----- rtl/core/teq_store.sv -----
// ----------------------------------------------------------------------------
// teq_store: event entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module teq_store import teq_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  teq_entry_t    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output teq_entry_t    rd_data
);

	teq_entry_t mem [DEPTH];
	teq_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/timed_event_queue.sv -----
// ----------------------------------------------------------------------------
// timed_event_queue: time-sorted event store with a running clock
// Add, list add, remove at time and advance time over one entry memory.
// ----------------------------------------------------------------------------
// One word in at a time; the block is busy until its last result word is
// loaded into the output register. A rejected add or list add goes straight
// to the flush state; an accepted add shifts every stored entry due later
// than the new one up one place, one per cycle, reading it through the read
// port and writing it back through the write port, then writes the new entry.
// Remove and advance walk every stored entry once, one per cycle while the
// output side does not stall, compacting the store in place; on an empty
// store they go straight to the flush state. The output side can stall the
// block at the final word and while advance fires events.
// ----------------------------------------------------------------------------
module timed_event_queue import teq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [TIME_W-1:0]    time_value,
	input  logic [ID_W-1:0]      event_id,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic                 fired_valid,
	output logic [ID_W-1:0]      fired_event,
	output logic [TIME_W-1:0]    fired_time,
	output logic [REMOVED_W-1:0] removed_count,
	output logic [TIME_W-1:0]    current_time,
	output logic                 last
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned RW = (CW > REMOVED_W) ? CW : REMOVED_W;

	teq_state_t            state_q, state_d;
	teq_op_t               op_q, op_d;
	teq_status_t           status_q, status_d;
	logic [TIME_W-1:0]     tv_q, tv_d;
	logic [ID_W-1:0]       ev_q, ev_d;
	logic [TIME_W-1:0]     now_q, now_d;
	logic [TIME_W-1:0]     start_q, start_d;
	logic [TIME_W-1:0]     end_q, end_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         pos_q, pos_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic [CW-1:0]         keep_q, keep_d;
	logic [CW-1:0]         removed_q, removed_d;
	logic [FIRED_W-1:0]    nf_q, nf_d;
	logic                  pend_v_q, pend_v_d;
	teq_entry_t            pend_q, pend_d;

	logic                  out_valid_q;
	teq_status_t           out_status_q;
	logic                  out_fvalid_q;
	teq_entry_t            out_fired_q;
	logic [REMOVED_W-1:0]  out_removed_q;
	logic [TIME_W-1:0]     out_now_q;
	logic                  out_last_q;

	logic                  out_load;
	logic                  out_fvalid_d;
	teq_entry_t            out_fired_d;
	logic [REMOVED_W-1:0]  out_removed_d;
	logic                  out_last_d;
	logic                  out_free;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	teq_entry_t            wr_data, rd_data;

	logic [TIME_W-1:0]     cmp_a, cmp_b, cmp_c;
	teq_cmp_t              cmp;

	logic [TIME_W:0]       adv_sum;
	logic [TIME_W-1:0]     adv_end;
	logic                  full;
	logic [CW-1:0]         pos_m1, pos_m2, idx_p1, keep_p1;
	logic                  drop, report, stall;
	logic [RW-1:0]         removed_ext;
	logic [REMOVED_W-1:0]  removed_sat;
	teq_entry_t            new_entry;

	teq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	teq_cmp u_cmp (
		.a     (cmp_a),
		.b     (cmp_b),
		.c     (cmp_c),
		.flags (cmp)
	);

	// window end saturates at the top of the time range
	assign adv_sum = {1'b0, now_q} + {1'b0, time_value};
	assign adv_end = adv_sum[TIME_W] ? {TIME_W{1'b1}} : adv_sum[TIME_W-1:0];

	assign full        = (count_q == CW'(QUEUE_DEPTH));
	assign pos_m1      = pos_q - CW'(1);
	assign pos_m2      = pos_q - CW'(2);
	assign idx_p1      = idx_q + CW'(1);
	assign keep_p1     = keep_q + CW'(1);
	assign new_entry   = '{due_time: tv_q, event_id: ev_q};
	assign removed_ext = RW'(removed_q);
	assign removed_sat = (removed_ext > RW'(31)) ? REMOVED_W'(31)
	                                             : removed_ext[REMOVED_W-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	assign drop   = (op_q == OP_REMOVE) ? cmp.eq_ab : (!cmp.lt_ab && !cmp.gt_ac);
	assign report = (op_q == OP_ADVANCE) && drop && (nf_q < FIRED_W'(MAX_FIRED));
	// a second fired word must wait until the held one can go out
	assign stall  = report && pend_v_q && !out_free;

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		status_d      = status_q;
		tv_d          = tv_q;
		ev_d          = ev_q;
		now_d         = now_q;
		start_d       = start_q;
		end_d         = end_q;
		count_d       = count_q;
		pos_d         = pos_q;
		idx_d         = idx_q;
		keep_d        = keep_q;
		removed_d     = removed_q;
		nf_d          = nf_q;
		pend_v_d      = pend_v_q;
		pend_d        = pend_q;
		wr_en         = 1'b0;
		wr_addr       = '0;
		wr_data       = rd_data;
		rd_en         = 1'b0;
		rd_addr       = '0;
		out_load      = 1'b0;
		out_fvalid_d  = 1'b0;
		out_fired_d   = '0;
		out_removed_d = '0;
		out_last_d    = 1'b0;
		cmp_a         = rd_data.due_time;
		cmp_b         = (op_q == OP_REMOVE) ? tv_q : start_q;
		cmp_c         = (state_q == S_INS_WALK) ? tv_q : end_q;

		case (state_q)
			S_IDLE: begin
				cmp_a = time_value;
				cmp_b = now_q;
				cmp_c = now_q;
				if (in_valid) begin
					op_d      = teq_op_t'(opcode);
					tv_d      = time_value;
					ev_d      = event_id;
					status_d  = STAT_OK;
					removed_d = '0;
					nf_d      = '0;
					pend_v_d  = 1'b0;
					idx_d     = '0;
					keep_d    = '0;
					pos_d     = count_q;
					case (teq_op_t'(opcode))
						OP_ADD: begin
							if (event_id == '0) begin
								status_d = STAT_REJ_EMPTY;
								state_d  = S_FLUSH;
							end else if (cmp.lt_ab) begin
								status_d = STAT_REJ_PAST;
								state_d  = S_FLUSH;
							end else if (full) begin
								status_d = STAT_FULL;
								state_d  = S_FLUSH;
							end else begin
								state_d = S_INS_RD;
							end
						end
						OP_LIST_ADD: begin
							if (!cmp.gt_ac) begin
								status_d = STAT_REJ_PAST;
								state_d  = S_FLUSH;
							end else if (full) begin
								status_d = STAT_FULL;
								state_d  = S_FLUSH;
							end else begin
								state_d = S_INS_RD;
							end
						end
						OP_REMOVE: begin
							state_d = (count_q == '0) ? S_FLUSH : S_CMP_RD;
						end
						OP_ADVANCE: begin
							start_d = now_q;
							end_d   = adv_end;
							now_d   = adv_end;
							state_d = (count_q == '0) ? S_FLUSH : S_CMP_RD;
						end
						default: begin
							state_d = S_FLUSH;
						end
					endcase
				end
			end

			S_INS_RD: begin
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = new_entry;
					count_d = count_q + CW'(1);
					state_d = S_FLUSH;
				end else begin
					rd_en   = 1'b1;
					rd_addr = pos_m1[AW-1:0];
					state_d = S_INS_WALK;
				end
			end

			S_INS_WALK: begin
				// read data holds the entry just below the insertion point
				if (cmp.gt_ac) begin
					wr_en   = 1'b1;
					wr_addr = pos_q[AW-1:0];
					wr_data = rd_data;
					pos_d   = pos_m1;
					if (pos_m1 == '0) begin
						state_d = S_INS_RD;
					end else begin
						rd_en   = 1'b1;
						rd_addr = pos_m2[AW-1:0];
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_q[AW-1:0];
					wr_data = new_entry;
					count_d = count_q + CW'(1);
					state_d = S_FLUSH;
				end
			end

			S_CMP_RD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = S_CMP_WALK;
			end

			S_CMP_WALK: begin
				if (!stall) begin
					if (drop && (op_q == OP_REMOVE)) begin
						removed_d = removed_q + CW'(1);
					end
					if (report) begin
						// the held word is not the last, another one follows
						if (pend_v_q) begin
							out_load     = 1'b1;
							out_fvalid_d = 1'b1;
							out_fired_d  = pend_q;
						end
						pend_d   = rd_data;
						pend_v_d = 1'b1;
						nf_d     = nf_q + FIRED_W'(1);
					end
					if (!drop) begin
						wr_en   = 1'b1;
						wr_addr = keep_q[AW-1:0];
						wr_data = rd_data;
						keep_d  = keep_p1;
					end
					if (idx_p1 == count_q) begin
						count_d = drop ? keep_q : keep_p1;
						state_d = S_FLUSH;
					end else begin
						idx_d   = idx_p1;
						rd_en   = 1'b1;
						rd_addr = idx_p1[AW-1:0];
					end
				end
			end

			S_FLUSH: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_fvalid_d  = pend_v_q;
					out_fired_d   = pend_v_q ? pend_q : '0;
					out_removed_d = (op_q == OP_REMOVE) ? removed_sat : '0;
					out_last_d    = 1'b1;
					state_d       = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			now_q       <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			keep_q      <= '0;
			removed_q   <= '0;
			nf_q        <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			now_q     <= now_d;
			pos_q     <= pos_d;
			idx_q     <= idx_d;
			keep_q    <= keep_d;
			removed_q <= removed_d;
			nf_q      <= nf_d;
			pend_v_q  <= pend_v_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		status_q <= status_d;
		tv_q     <= tv_d;
		ev_q     <= ev_d;
		start_q  <= start_d;
		end_q    <= end_d;
		pend_q   <= pend_d;
		if (out_load) begin
			out_status_q  <= (state_q == S_FLUSH) ? status_q : STAT_OK;
			out_fvalid_q  <= out_fvalid_d;
			out_fired_q   <= out_fired_d;
			out_removed_q <= out_removed_d;
			out_now_q     <= now_q;
			out_last_q    <= out_last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign fired_valid   = out_fvalid_q;
	assign fired_event   = out_fired_q.event_id;
	assign fired_time    = out_fired_q.due_time;
	assign removed_count = out_removed_q;
	assign current_time  = out_now_q;
	assign last          = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count beyond store depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && out_valid_q && !out_ready))
		else $error("output word overwritten before it was taken");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP_WALK) |-> (keep_q <= idx_q))
		else $error("compaction write index ahead of read index");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_RD) |-> (count_q < CW'(QUEUE_DEPTH)))
		else $error("insert started on a full store");

	a_fired_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= FIRED_W'(MAX_FIRED))
		else $error("too many fired events reported");
`endif

endmodule

// ----- tb/timed_event_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_tb: self-checking bench for the timed event queue
// A scoreboard object keeps its own sorted copy of the store and the clock,
// predicts every result word of each accepted input word and checks the
// result stream in order. Directed corner cases first, then random traffic
// with random idling on both sides, one long output stall and a drain pause.
// ----------------------------------------------------------------------------
module timed_event_queue_tb;
	import teq_pkg::*;

	typedef struct packed {
		logic [1:0]           status;
		logic                 fired_valid;
		logic [ID_W-1:0]      fired_event;
		logic [TIME_W-1:0]    fired_time;
		logic [REMOVED_W-1:0] removed_count;
		logic [TIME_W-1:0]    current_time;
		logic                 last;
	} teq_result_t;

	class event_queue_scoreboard;
		logic [TIME_W-1:0] due[QUEUE_DEPTH_DEF];
		logic [ID_W-1:0]   ids[QUEUE_DEPTH_DEF];
		int unsigned       count;
		logic [TIME_W-1:0] now;
		teq_result_t       expected_q[$];
		int                errors;
		int                checked;
		int                fired_total;
		int                full_total;

		function new();
			count = 0;
			now = '0;
			errors = 0;
			checked = 0;
			fired_total = 0;
			full_total = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void queue_word(teq_result_t r);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// mostly a time that is in the store, so removes hit something
		function logic [TIME_W-1:0] pick_time();
			if (count > 0 && $urandom_range(99) < 70)
				return due[$urandom_range(count - 1)];
			return $urandom();
		endfunction

		// equal times go behind the ones already stored
		function teq_status_t store_event(logic [TIME_W-1:0] tv, logic [ID_W-1:0] id);
			int unsigned pos;
			if (count >= QUEUE_DEPTH_DEF) begin
				full_total++;
				return STAT_FULL;
			end
			pos = count;
			while (pos > 0 && due[pos-1] > tv) begin
				due[pos] = due[pos-1];
				ids[pos] = ids[pos-1];
				pos--;
			end
			due[pos] = tv;
			ids[pos] = id;
			count++;
			return STAT_OK;
		endfunction

		function void note_input(teq_op_t op, logic [TIME_W-1:0] tv, logic [ID_W-1:0] id);
			teq_result_t       r;
			teq_result_t       fired_q[$];
			logic [TIME_W-1:0] start;
			logic [TIME_W-1:0] win_end;
			int unsigned       keep;
			int unsigned       removed;
			r = '0;
			r.last = 1'b1;
			case (op)
				OP_ADD: begin
					if (id == '0)
						r.status = STAT_REJ_EMPTY;
					else if (tv < now)
						r.status = STAT_REJ_PAST;
					else
						r.status = store_event(tv, id);
					r.current_time = now;
					queue_word(r);
				end
				OP_LIST_ADD: begin
					if (!(tv > now))
						r.status = STAT_REJ_PAST;
					else
						r.status = store_event(tv, id);
					r.current_time = now;
					queue_word(r);
				end
				OP_REMOVE: begin
					keep = 0;
					removed = 0;
					for (int i = 0; i < count; i++) begin
						if (due[i] == tv) begin
							removed++;
						end else begin
							due[keep] = due[i];
							ids[keep] = ids[i];
							keep++;
						end
					end
					count = keep;
					if (removed > 2**REMOVED_W - 1)
						removed = 2**REMOVED_W - 1;
					r.status = STAT_OK;
					r.removed_count = REMOVED_W'(removed);
					r.current_time = now;
					queue_word(r);
				end
				default: begin
					start = now;
					win_end = (tv > {TIME_W{1'b1}} - start) ? {TIME_W{1'b1}} : start + tv;
					keep = 0;
					for (int i = 0; i < count; i++) begin
						if (due[i] >= start && due[i] <= win_end) begin
							// beyond the report limit an event is dropped silently
							if (fired_q.size() < MAX_FIRED) begin
								r = '0;
								r.status = STAT_OK;
								r.fired_valid = 1'b1;
								r.fired_event = ids[i];
								r.fired_time = due[i];
								r.current_time = win_end;
								fired_q.insert(fired_q.size(), r);
							end
						end else begin
							due[keep] = due[i];
							ids[keep] = ids[i];
							keep++;
						end
					end
					count = keep;
					now = win_end;
					if (fired_q.size() == 0) begin
						r = '0;
						r.status = STAT_OK;
						r.current_time = now;
						r.last = 1'b1;
						queue_word(r);
					end else begin
						fired_q[fired_q.size()-1].last = 1'b1;
						fired_total += fired_q.size();
						foreach (fired_q[k])
							queue_word(fired_q[k]);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want, int idx);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s got %0h want %0h",
					idx, name, got, want));
		endtask

		task check_result(teq_result_t got);
			teq_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			want = expected_q.pop_front();
			check_field("status", 32'(got.status), 32'(want.status), checked);
			check_field("fired_valid", 32'(got.fired_valid), 32'(want.fired_valid),
				checked);
			check_field("fired_event", 32'(got.fired_event), 32'(want.fired_event),
				checked);
			check_field("fired_time", got.fired_time, want.fired_time, checked);
			check_field("removed_count", 32'(got.removed_count),
				32'(want.removed_count), checked);
			check_field("current_time", got.current_time, want.current_time, checked);
			check_field("last", 32'(got.last), 32'(want.last), checked);
			checked++;
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           opcode;
	logic [TIME_W-1:0]    time_value;
	logic [ID_W-1:0]      event_id;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           status;
	logic                 fired_valid;
	logic [ID_W-1:0]      fired_event;
	logic [TIME_W-1:0]    fired_time;
	logic [REMOVED_W-1:0] removed_count;
	logic [TIME_W-1:0]    current_time;
	logic                 last;

	event_queue_scoreboard sb;
	bit no_idle;
	bit hold_req;
	int words_sent;

	timed_event_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.time_value   (time_value),
		.event_id     (event_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.fired_valid  (fired_valid),
		.fired_event  (fired_event),
		.fired_time   (fired_time),
		.removed_count(removed_count),
		.current_time (current_time),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timed_event_queue_tb: FAIL");
		$finish;
	end

	// valid stays high from one word to the next unless an idle cycle is taken
	task automatic send_word(teq_op_t op, logic [TIME_W-1:0] tv, logic [ID_W-1:0] id);
		while (!no_idle && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		time_value <= tv;
		event_id <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(op, tv, id);
		words_sent++;
	endtask

	// result side: check, then pick out_ready for the next cycle
	initial begin
		teq_result_t got;
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.status = status;
				got.fired_valid = fired_valid;
				got.fired_event = fired_event;
				got.fired_time = fired_time;
				got.removed_count = removed_count;
				got.current_time = current_time;
				got.last = last;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1;
				hold_left = 399;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin
		teq_op_t           op;
		logic [TIME_W-1:0] tv;
		logic [ID_W-1:0]   id;
		int unsigned       r;
		sb = new();
		words_sent = 0;
		no_idle = 0;
		hold_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ADD;
		time_value = '0;
		event_id = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: rejects, ties, windows and a full store
		send_word(OP_ADD, 32'd5, 16'h0000);
		send_word(OP_ADD, 32'd0, 16'hFFFF);
		send_word(OP_LIST_ADD, 32'd0, 16'h0002);
		send_word(OP_LIST_ADD, 32'd1, 16'h0000);
		send_word(OP_ADD, 32'd7, 16'h0003);
		send_word(OP_ADD, 32'd7, 16'h0004);
		send_word(OP_ADD, 32'd3, 16'h0005);
		send_word(OP_ADVANCE, 32'd0, 16'h0000);
		send_word(OP_ADVANCE, 32'd5, 16'h0000);
		send_word(OP_ADD, 32'd4, 16'h0006);
		send_word(OP_LIST_ADD, 32'd5, 16'h0007);
		for (int k = 0; k < 14; k++)
			send_word(OP_ADD, TIME_W'(5 + k % 4), ID_W'(32'h8000 | k));
		send_word(OP_ADD, 32'd9, 16'h00AA);
		send_word(OP_LIST_ADD, 32'd6, 16'h00BB);
		send_word(OP_ADVANCE, 32'd50, 16'h0000);

		// random traffic, well-formed mostly, with some noise words
		for (int i = 0; i < 300; i++) begin
			if (i == 100)
				hold_req <= 1'b1;
			if (i == 150)
				no_idle <= 1'b1;
			if (i == 200)
				no_idle <= 1'b0;
			if (i == 230) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			r = $urandom_range(99);
			id = ID_W'($urandom());
			if (r < 30) begin
				op = OP_ADD;
				tv = sb.now + $urandom_range(40);
				if (id == '0)
					id = 16'h0001;
			end else if (r < 40) begin
				op = OP_LIST_ADD;
				tv = sb.now + $urandom_range(40, 1);
			end else if (r < 52) begin
				op = OP_REMOVE;
				tv = sb.pick_time();
			end else if (r < 85) begin
				op = OP_ADVANCE;
				tv = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(60);
			end else if (r < 89) begin
				op = OP_ADD;
				tv = sb.now + $urandom_range(10);
				id = '0;
			end else if (r < 93) begin
				op = OP_ADD;
				tv = (sb.now == 0) ? 32'd0 : $urandom_range(sb.now - 1);
				if (sb.now == 0)
					id = '0;
			end else if (r < 97) begin
				op = OP_LIST_ADD;
				tv = sb.now;
			end else begin
				op = OP_ADVANCE;
				tv = '0;
			end
			send_word(op, tv, id);
		end

		// clock saturation at the top of the time range
		send_word(OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000);
		send_word(OP_ADD, 32'hFFFF_FFFF, 16'hABCD);
		send_word(OP_LIST_ADD, 32'hFFFF_FFFF, 16'h1234);
		send_word(OP_ADD, 32'h0000_0000, 16'h4321);
		send_word(OP_ADVANCE, 32'd1, 16'h0000);
		send_word(OP_ADVANCE, 32'd0, 16'h0000);

		in_valid <= 1'b0;
		no_idle <= 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d input words and %0d result words: %0d events fired,",
			words_sent, sb.checked, sb.fired_total);
		$display("%0d full-store rejections, one long output stall and clock saturation",
			sb.full_total);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("timed_event_queue_tb: PASS");
		end else begin
			$display("timed_event_queue_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/teq_pkg.sv
rtl/core/teq_cmp.sv
rtl/core/teq_store.sv
rtl/core/timed_event_queue.sv
tb/timed_event_queue_tb.sv
